// ===== rtl/kwsc_pkg.sv =====
// Shared types, constants and helper functions for the k-mer window sparsity counter.
`default_nettype none

package kwsc_pkg;

  // Sizing of the k-mer and window.
  localparam int MAX_K      = 8;
  localparam int MAX_W      = 63;
  localparam int KMER_W     = 16;
  localparam int KBITS_W    = 5;
  localparam int HIT_W      = 7;
  localparam int PRIME_W    = 7;
  localparam int COUNT_W    = 32;
  localparam int SYM_W      = 2;
  localparam int KLEN_W     = 4;
  localparam int WLEN_W     = 6;
  localparam int BPS_W      = 2;
  localparam int HIST_DEPTH = MAX_W + 1;

  // Membership bitmap organized as rows of bits.
  localparam int ROW_W    = 64;
  localparam int BIT_AW   = 6;
  localparam int ROWS     = (1 << KMER_W) / ROW_W;
  localparam int ROW_AW   = KMER_W - BIT_AW;

  // Small queue between the front and back parts.
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = 2;
  localparam int Q_CNT_W  = 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_KMER_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BPS        = 2'd2;

  // Request type codes.
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SYMBOL = 1'b1;

  // Operation codes handed from the front to the back.
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_SKIP,
    OP_FILL,
    OP_EVAL
  } op_e_t;

  typedef struct packed {
    op_e_t             code;
    logic [KMER_W-1:0] addr;
    logic              flag;
  } kwsc_op_t;

  // Configuration after saturation to the legal ranges.
  typedef struct packed {
    logic [KLEN_W-1:0] k;
    logic [WLEN_W-1:0] w;
    logic              bps2;
  } cfg_t;

  function automatic cfg_t cfg_clamp(input logic [KLEN_W-1:0] k_raw,
                                     input logic [WLEN_W-1:0] w_raw,
                                     input logic [BPS_W-1:0]  b_raw);
    cfg_t c;
    if (k_raw == '0) begin
      c.k = KLEN_W'(1);
    end else if (k_raw > KLEN_W'(MAX_K)) begin
      c.k = KLEN_W'(MAX_K);
    end else begin
      c.k = k_raw;
    end
    c.w    = (w_raw == '0) ? WLEN_W'(1) : w_raw;
    // Codes 2 and 3 select two-bit symbols, codes 0 and 1 single-bit symbols.
    c.bps2 = b_raw[1];
    return c;
  endfunction

  function automatic logic [KMER_W-1:0] kmer_mask(input logic [KBITS_W-1:0] kbits);
    logic [KBITS_W-1:0] sh;
    sh = KBITS_W'(KMER_W) - kbits;
    return {KMER_W{1'b1}} >> sh;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kwsc_item_if.sv =====
// Input channel carrying table writes and sequence symbols.
`default_nettype none

interface kwsc_item_if import kwsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [KMER_W-1:0] table_index;
  logic              member_flag;
  logic [SYM_W-1:0]  symbol;

  modport source (output valid, output req_type, output table_index,
                  output member_flag, output symbol, input ready);
  modport sink   (input valid, input req_type, input table_index,
                  input member_flag, input symbol, output ready);
endinterface

`default_nettype wire

// ===== rtl/kwsc_result_if.sv =====
// Output channel carrying one window result per sequence symbol.
`default_nettype none

interface kwsc_result_if import kwsc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               window_valid;
  logic               sparse_flag;
  logic [HIT_W-1:0]   hits_in_window;
  logic [COUNT_W-1:0] sparse_count;
  logic [COUNT_W-1:0] total_count;

  modport source (output valid, output window_valid, output sparse_flag,
                  output hits_in_window, output sparse_count, output total_count,
                  input ready);
  modport sink   (input valid, input window_valid, input sparse_flag,
                  input hits_in_window, input sparse_count, input total_count,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/kwsc_front.sv =====
// Front part: accepts items, rolls the k-mer and classifies each symbol by priming phase.
`default_nettype none

module kwsc_front import kwsc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  kwsc_item_if.sink    item,
  input  cfg_t         cfg,
  input  logic         cfg_restart,
  input  logic         clr_busy,
  output logic         push_valid,
  input  logic         push_ready,
  output kwsc_op_t     push_op
);

  logic [KMER_W-1:0]  kmer;
  logic [KMER_W-1:0]  kmer_next;
  logic [KMER_W-1:0]  kmer_shifted;
  logic [PRIME_W-1:0] prime_count;
  logic [PRIME_W-1:0] k_minus1;
  logic [PRIME_W-1:0] prime_limit;
  logic [KBITS_W-1:0] kbits;
  logic [SYM_W-1:0]   sym;
  logic               accept;
  logic               prime_advance;
  op_e_t              sym_code;

  // Nothing is taken while the bitmap is being cleared.
  assign item.ready = push_ready && !clr_busy;
  assign push_valid = item.valid && !clr_busy;
  assign accept     = item.valid && item.ready;

  // Shift the masked symbol into the k-mer.
  assign sym          = cfg.bps2 ? item.symbol : {1'b0, item.symbol[0]};
  assign kbits        = cfg.bps2 ? {cfg.k, 1'b0} : {1'b0, cfg.k};
  assign kmer_shifted = cfg.bps2 ? {kmer[KMER_W-3:0], sym} : {kmer[KMER_W-2:0], sym[0]};
  assign kmer_next    = kmer_shifted & kmer_mask(kbits);

  // Priming phases: fill the k-mer, then fill the window, then evaluate.
  assign k_minus1    = PRIME_W'(cfg.k) - PRIME_W'(1);
  assign prime_limit = k_minus1 + PRIME_W'(cfg.w);

  always_comb begin
    if (prime_count < k_minus1) begin
      sym_code      = OP_SKIP;
      prime_advance = 1'b1;
    end else if (prime_count < prime_limit) begin
      sym_code      = OP_FILL;
      prime_advance = 1'b1;
    end else begin
      sym_code      = OP_EVAL;
      prime_advance = 1'b0;
    end
  end

  // Operation pushed into the queue.
  always_comb begin
    if (item.req_type == REQ_WRITE) begin
      push_op.code = OP_WRITE;
      push_op.addr = item.table_index;
      push_op.flag = item.member_flag;
    end else begin
      push_op.code = sym_code;
      push_op.addr = kmer_next;
      push_op.flag = 1'b0;
    end
  end

  // K-mer and priming state; a configuration write restarts the stream.
  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      kmer        <= '0;
      prime_count <= '0;
    end else if (accept && item.req_type == REQ_SYMBOL) begin
      kmer <= kmer_next;
      if (prime_advance) begin
        prime_count <= prime_count + PRIME_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kwsc_queue.sv =====
// Short queue of classified operations between the front and back parts.
`default_nettype none

module kwsc_queue import kwsc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  kwsc_op_t push_op,
  output logic     pop_valid,
  input  logic     pop_ready,
  output kwsc_op_t pop_op
);

  kwsc_op_t           slots [Q_DEPTH];
  logic [Q_AW-1:0]    wr_ptr;
  logic [Q_AW-1:0]    rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               push;
  logic               pop;

  assign push_ready = (count != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Storage; no reset needed for payload.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kwsc_back.sv =====
// Back part: membership bitmap, hit history, window counters and the result register.
`default_nettype none

module kwsc_back import kwsc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          cfg_restart,
  output logic          clr_busy,
  input  logic          q_valid,
  output logic          q_ready,
  input  kwsc_op_t      q_op,
  kwsc_result_if.source result
);

  // Bitmap memory and its clearing pass.
  logic [ROW_W-1:0]  bitmap_mem [ROWS];
  logic [ROW_W-1:0]  rd_row;
  logic [ROW_AW-1:0] clr_row;

  // Lookup stage.
  logic              s1_valid;
  op_e_t             s1_code;
  logic [BIT_AW-1:0] s1_bit;
  logic              pop;
  logic              s1_adv;

  // Window state.
  logic [HIST_DEPTH-1:0] hit_hist;
  logic [HIT_W-1:0]      hit_total;
  logic [COUNT_W-1:0]    sparse_total;
  logic [COUNT_W-1:0]    window_total;

  // Result register.
  logic               out_valid;
  logic               out_window;
  logic               out_sparse;
  logic [HIT_W-1:0]   out_hits;
  logic [COUNT_W-1:0] out_sparse_count;
  logic [COUNT_W-1:0] out_total_count;

  logic               hit;
  logic               oldest;
  logic [HIT_W-1:0]   hit_sum;
  logic [HIT_W-1:0]   hit_total_next;
  logic [HIT_W-1:0]   shown;
  logic               is_eval;
  logic               is_sparse;
  logic               shift_hit;
  logic [COUNT_W-1:0] sparse_total_next;
  logic [COUNT_W-1:0] window_total_next;

  // Handshake between the queue, the lookup stage and the result register.
  assign s1_adv  = s1_valid && (!out_valid || result.ready);
  assign pop     = q_valid && !clr_busy && (!s1_valid || s1_adv);
  assign q_ready = pop;

  // Clearing pass after reset, one row per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_row  <= '0;
    end else if (clr_busy) begin
      clr_row <= clr_row + ROW_AW'(1);
      if (clr_row == ROW_AW'(ROWS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Bitmap port: clear or single-bit write, plus registered row read.
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      bitmap_mem[clr_row] <= '0;
    end else if (pop && q_op.code == OP_WRITE) begin
      bitmap_mem[q_op.addr[KMER_W-1:BIT_AW]][q_op.addr[BIT_AW-1:0]] <= q_op.flag;
    end
    if (pop) begin
      rd_row <= bitmap_mem[q_op.addr[KMER_W-1:BIT_AW]];
    end
  end

  // Lookup stage control; table writes finish at the memory and leave no result.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pop) begin
      s1_valid <= (q_op.code != OP_WRITE);
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_code <= q_op.code;
      s1_bit  <= q_op.addr[BIT_AW-1:0];
    end
  end

  // Window arithmetic for the symbol in the lookup stage.
  assign hit     = rd_row[s1_bit];
  assign oldest  = hit_hist[cfg.w - WLEN_W'(1)];
  assign hit_sum = hit_total + HIT_W'(hit);

  always_comb begin
    shown          = hit_total;
    hit_total_next = hit_total;
    is_eval        = 1'b0;
    shift_hit      = 1'b0;
    unique case (s1_code)
      OP_WRITE: begin
      end
      OP_SKIP: begin
      end
      OP_FILL: begin
        shown          = hit_sum;
        hit_total_next = hit_sum;
        shift_hit      = 1'b1;
      end
      OP_EVAL: begin
        shown          = hit_sum;
        hit_total_next = hit_sum - HIT_W'(oldest);
        is_eval        = 1'b1;
        shift_hit      = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign is_sparse = is_eval && (hit_sum == HIT_W'(1));

  // Saturating counters.
  always_comb begin
    window_total_next = window_total;
    sparse_total_next = sparse_total;
    if (is_eval && window_total != '1) begin
      window_total_next = window_total + COUNT_W'(1);
    end
    if (is_sparse && sparse_total != '1) begin
      sparse_total_next = sparse_total + COUNT_W'(1);
    end
  end

  // Window state updates as a symbol leaves the lookup stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_total    <= '0;
      sparse_total <= '0;
      window_total <= '0;
    end else if (cfg_restart) begin
      hit_total <= '0;
    end else if (s1_adv) begin
      hit_total    <= hit_total_next;
      sparse_total <= sparse_total_next;
      window_total <= window_total_next;
    end
  end

  // Hit history line; entries are always refilled during priming before use.
  always_ff @(posedge clk) begin
    if (s1_adv && shift_hit) begin
      hit_hist <= {hit_hist[HIST_DEPTH-2:0], hit};
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_window       <= is_eval;
      out_sparse       <= is_sparse;
      out_hits         <= shown;
      out_sparse_count <= sparse_total_next;
      out_total_count  <= window_total_next;
    end
  end

  assign result.valid          = out_valid;
  assign result.window_valid   = out_window;
  assign result.sparse_flag    = out_sparse;
  assign result.hits_in_window = out_hits;
  assign result.sparse_count   = out_sparse_count;
  assign result.total_count    = out_total_count;

endmodule

`default_nettype wire

// ===== rtl/kmer_window_sparsity_counter.sv =====
// Top level of the k-mer window sparsity counter: configuration registers and wiring.
//
// The item channel carries either a table write (req_type 0), which writes one bit
// of the 65536-entry membership bitmap, or a sequence symbol (req_type 1).
// Each symbol yields one transfer on the result channel with the window flags,
// the hit count and the saturating sparse and total counters; table writes yield
// none. Items are taken one per cycle while the queue has room and no clearing
// pass runs. A result passes the queue, the registered bitmap row read and the
// result register. After reset the bitmap is cleared one 64-bit row per cycle,
// 1024 rows in all; during that pass item.ready is low, configuration writes are
// still taken. When the receiver stalls, the result register holds, then the
// lookup stage, then a four-entry queue fills before item.ready drops.
// The user must make configuration writes (cfg_we, cfg_index, cfg_data) only while
// the block is idle; the block does not enforce it. Each one restarts priming of
// the k-mer and window, while the bitmap and both counters are kept.
`default_nettype none

module kmer_window_sparsity_counter import kwsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  kwsc_item_if.sink             item,
  kwsc_result_if.source         result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [KLEN_W-1:0] kmer_len;
  logic [WLEN_W-1:0] window_len;
  logic [BPS_W-1:0]  bits_per_symbol;
  cfg_t              cfg;
  logic              cfg_restart;
  logic              clr_busy;
  logic              push_valid;
  logic              push_ready;
  kwsc_op_t          push_op;
  logic              q_valid;
  logic              q_ready;
  kwsc_op_t          q_op;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len        <= KLEN_W'(8);
      window_len      <= WLEN_W'(10);
      bits_per_symbol <= BPS_W'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KMER_LEN:   kmer_len        <= cfg_data[KLEN_W-1:0];
        CFG_WINDOW_LEN: window_len      <= cfg_data[WLEN_W-1:0];
        CFG_BPS:        bits_per_symbol <= cfg_data[BPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_restart = cfg_we && (cfg_index == CFG_KMER_LEN || cfg_index == CFG_WINDOW_LEN
                                  || cfg_index == CFG_BPS);
  assign cfg         = cfg_clamp(kmer_len, window_len, bits_per_symbol);

  kwsc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cfg         (cfg),
    .cfg_restart (cfg_restart),
    .clr_busy    (clr_busy),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_op     (push_op)
  );

  kwsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_op     (q_op)
  );

  kwsc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cfg_restart (cfg_restart),
    .clr_busy    (clr_busy),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_op        (q_op),
    .result      (result)
  );

  // No item may enter while the bitmap clearing pass runs.
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !(item.valid && item.ready))
    else $error("item transfer during bitmap clearing");

  // No result can exist before the clearing pass is over.
  a_no_result_clearing: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !result.valid)
    else $error("result pending during bitmap clearing");

  // A sparse window holds exactly one member and is a full window.
  a_sparse_one_hit: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.sparse_flag) |->
      (result.window_valid && result.hits_in_window == HIT_W'(1)))
    else $error("sparse flag without exactly one hit");

  // Sparse windows never outnumber evaluated windows.
  a_counts_ordered: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.sparse_count <= result.total_count))
    else $error("sparse count exceeds total count");

endmodule

`default_nettype wire
